### hw/rtl/dq_pkg.sv
// Shared types and codes for the double-ended queue.
// Holds operation and status codes, controller states and the
// command/status structs between controller and datapath.
package dq_pkg;

    typedef enum logic [2:0] {
        OP_ADD_FRONT = 3'd0,
        OP_ADD_REAR  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_REAR  = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR = 3'd5,
        OP_DUMP      = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_UNDER = 2'd2,
        ST_OVER  = 2'd3
    } res_status_t;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_DRAIN = 1'b1
    } state_t;

    localparam int WORD_W = 32;

    // Controller to datapath
    typedef struct packed {
        logic exec;     // execute the transaction on the input side
        logic load_rd;  // move read data into the output register
    } dq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic needs_read;  // presented op reads the store
        logic out_free;    // output register free this cycle
        logic drain_more;  // further words remain after the current one
    } dq_stat_t;

endpackage

### hw/rtl/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/dq_ctrl.sv
// Controller state machine for the double-ended queue.
// Depends on dq_pkg; drives commands to dq_dp.
module dq_ctrl
    import dq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dq_stat_t stat,
    output dq_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load_rd = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    cmd.exec = 1'b1;
                    if (stat.needs_read)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                // read data is ready; hand it over once the output frees up
                if (stat.out_free)
                begin
                    cmd.load_rd = 1'b1;
                    if (!stat.drain_more)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/dq_dp.sv
// Datapath of the double-ended queue: pointers, count, ring store,
// drain counter and output register. Depends on dq_pkg and dq_ram.
module dq_dp
    import dq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  op_t               op,
    input  logic [WORD_W-1:0] value,
    input  dq_cmd_t           cmd,
    output dq_stat_t          stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] value_res,
    output res_status_t       status,
    output logic              last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] rear_reg, rear_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] rem_reg, rem_next;

    logic              ov_reg, ov_next;
    logic [WORD_W-1:0] ovalue_reg, ovalue_next;
    res_status_t       ostat_reg, ostat_next;
    logic              olast_reg, olast_next;

    logic              we;
    logic [AW-1:0]     waddr;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [WORD_W-1:0] rdata;

    logic [AW-1:0] front_inc, front_dec, rear_inc, rear_dec, pos_inc;
    logic          empty, full, needs_read;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
    endfunction

    assign front_inc = ptr_inc(front_reg);
    assign front_dec = ptr_dec(front_reg);
    assign rear_inc  = ptr_inc(rear_reg);
    assign rear_dec  = ptr_dec(rear_reg);
    assign pos_inc   = ptr_inc(pos_reg);
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(DEPTH));

    assign needs_read = !empty &&
                        (op == OP_PEEK_FRONT || op == OP_PEEK_REAR || op == OP_DUMP);

    assign stat.needs_read = needs_read;
    assign stat.out_free   = !ov_reg || out_ready;
    assign stat.drain_more = (rem_reg > CW'(1));

    always_comb
    begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        ov_next     = ov_reg && !out_ready;
        ovalue_next = ovalue_reg;
        ostat_next  = ostat_reg;
        olast_next  = olast_reg;
        we          = 1'b0;
        waddr       = rear_reg;
        re          = 1'b0;
        raddr       = front_reg;

        if (cmd.exec)
        begin
            ovalue_next = '0;
            ostat_next  = ST_OK;
            olast_next  = 1'b1;
            ov_next     = !needs_read;
            unique case (op)
                OP_ADD_FRONT, OP_ADD_REAR:
                begin
                    if (full)
                    begin
                        ostat_next = ST_OVER;
                    end
                    else
                    begin
                        we         = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (op == OP_ADD_FRONT)
                        begin
                            waddr      = front_dec;
                            front_next = front_dec;
                        end
                        else
                        begin
                            waddr     = rear_reg;
                            rear_next = rear_inc;
                        end
                    end
                end
                OP_DEL_FRONT, OP_DEL_REAR:
                begin
                    if (empty)
                    begin
                        ostat_next = ST_UNDER;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        if (op == OP_DEL_FRONT)
                        begin
                            front_next = front_inc;
                        end
                        else
                        begin
                            rear_next = rear_dec;
                        end
                    end
                end
                OP_PEEK_FRONT, OP_PEEK_REAR:
                begin
                    if (empty)
                    begin
                        ovalue_next = '1;
                        ostat_next  = ST_EMPTY;
                    end
                    else
                    begin
                        re       = 1'b1;
                        raddr    = (op == OP_PEEK_FRONT) ? front_reg : rear_dec;
                        rem_next = CW'(1);
                    end
                end
                OP_DUMP:
                begin
                    if (empty)
                    begin
                        ostat_next = ST_EMPTY;
                    end
                    else
                    begin
                        re       = 1'b1;
                        raddr    = front_reg;
                        pos_next = front_inc;
                        rem_next = count_reg;
                    end
                end
                default:
                begin
                    // unused code: plain ok result, state untouched
                end
            endcase
        end
        else if (cmd.load_rd)
        begin
            ov_next     = 1'b1;
            ovalue_next = rdata;
            ostat_next  = ST_OK;
            olast_next  = (rem_reg == CW'(1));
            // advance to the next word of a dump
            if (rem_reg > CW'(1))
            begin
                re       = 1'b1;
                raddr    = pos_reg;
                pos_next = pos_inc;
                rem_next = rem_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            rem_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovalue_reg <= ovalue_next;
        ostat_reg  <= ostat_next;
        olast_reg  <= olast_next;
    end

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (value),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_valid = ov_reg;
    assign value_res = ovalue_reg;
    assign status    = ostat_reg;
    assign last      = olast_reg;

endmodule

### hw/rtl/double_ended_queue.sv
// Top level of the double-ended queue: stream ports, controller and datapath.
// Depends on dq_pkg, dq_ctrl and dq_dp (which holds dq_ram).
//
//   channel   | direction | tdata            | tuser        | tlast
//   ----------+-----------+------------------+--------------+------
//   s_*       | in        | value [31:0]     | op [2:0]     | -
//   m_*       | out       | value_res [31:0] | status [1:0] | last
//
// Add, delete, empty peek/dump and unused codes make no store read; the
// result lands in the output register on the accepting edge.
// A peek makes one registered store read; a dump of N words makes one store
// read per word, and no transaction is taken meanwhile.
// Reset (rst_n low, asynchronous) empties the queue; store contents are kept.
// A stalled output holds its result; the input waits until the output frees.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_res
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    dq_cmd_t     cmd;
    dq_stat_t    stat;
    res_status_t status;

    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op_t'(s_tuser)),
        .value     (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .value_res (m_tdata),
        .status    (status),
        .last      (m_tlast)
    );

    assign m_tuser = status;

endmodule
